FILE: sv/htq_pkg.sv
// Package for the heightfield triangle height query unit.
// Grid geometry, fixed-point widths, item codes and the constant divider.
// No dependencies.
`default_nettype none

package htq_pkg;

  // Grid geometry
  localparam int GRID_POINTS  = 21;
  localparam int CELL_SPACING = 5;
  localparam int HALF_POINTS  = (GRID_POINTS - 1) / 2;
  localparam int CELL_UNITS   = CELL_SPACING * 256;
  localparam int BASE_UNITS   = HALF_POINTS * CELL_UNITS;

  // Whole cells added so every 16-bit position maps to a non-negative offset
  localparam int OFFSET_CELLS = (32768 - BASE_UNITS + CELL_UNITS - 1) / CELL_UNITS;
  localparam int SHIFT_UNITS  = BASE_UNITS + OFFSET_CELLS * CELL_UNITS;

  // Field widths
  localparam int HEIGHT_W = 16;
  localparam int COORD_W  = 16;
  localparam int INDEX_W  = 5;
  localparam int RESET_HEIGHT = 2560;

  // Store addressing
  localparam int STORE_DEPTH = GRID_POINTS * GRID_POINTS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Internal datapath widths
  localparam int OFF_W   = 17;                         // shifted position
  localparam int CELLQ_W = 6;                          // shifted cell index
  localparam int WGT_W   = $clog2(CELL_UNITS + 1);     // in-cell offset / weight
  localparam int DIFF_W  = HEIGHT_W + 1;
  localparam int PROD_W  = DIFF_W + WGT_W + 1;
  localparam int NUM_W   = 32;
  localparam int NUM_BIAS = 32768 * CELL_UNITS;        // makes the blend sum non-negative

  // Divide by CELL_SPACING: multiply by a rounded-up reciprocal
  localparam int DIVX_W      = 19;
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + CELL_SPACING - 1) / CELL_SPACING;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int DIVQ_W      = DIVX_W;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } htq_op_e;

  // Request from the sequencer to the height store
  typedef struct packed {
    logic                         we;
    logic                         re;
    logic [ADDR_W-1:0]            addr;
    logic [HEIGHT_W-1:0]          wdata;
  } htq_mem_req_t;

  // Floor of x / CELL_SPACING, exact for x below 2**DIVX_W
  function automatic logic [DIVQ_W-1:0] div_spacing(input logic [DIVX_W-1:0] x);
    logic [DIVX_W+RECIP_W-1:0] prod;
    prod = (DIVX_W+RECIP_W)'(x) * (DIVX_W+RECIP_W)'(RECIP);
    return DIVQ_W'(prod >> RECIP_SHIFT);
  endfunction

endpackage

`default_nettype wire

FILE: sv/htq_item_if.sv
// Input item channel of the height query unit: valid/ready plus payload.
// Depends on htq_pkg.
`default_nettype none

interface htq_item_if import htq_pkg::*; ();
  logic                        valid;
  logic                        ready;
  htq_op_e                     opcode;
  logic [INDEX_W-1:0]          grid_row;
  logic [INDEX_W-1:0]          grid_col;
  logic signed [HEIGHT_W-1:0]  height_value;
  logic signed [COORD_W-1:0]   pos_x;
  logic signed [COORD_W-1:0]   pos_z;

  modport source (output valid, opcode, grid_row, grid_col, height_value, pos_x, pos_z,
                  input ready);
  modport sink   (input valid, opcode, grid_row, grid_col, height_value, pos_x, pos_z,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/htq_result_if.sv
// Result item channel of the height query unit: valid/ready plus payload.
// Depends on htq_pkg.
`default_nettype none

interface htq_result_if import htq_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [HEIGHT_W-1:0]  height_out;
  logic                        out_of_range;

  modport source (output valid, height_out, out_of_range, input ready);
  modport sink   (input valid, height_out, out_of_range, output ready);
endinterface

`default_nettype wire

FILE: sv/htq_store.sv
// Height store: single-port-write, single-port-read memory with a registered read port.
// Runs a clearing pass to the reset height after reset. Depends on htq_pkg.
`default_nettype none

module htq_store import htq_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire htq_mem_req_t         req_i,
  output logic [HEIGHT_W-1:0]       rd_data_o,
  output logic                      clearing_o
);

  logic [HEIGHT_W-1:0] mem_q [STORE_DEPTH];
  logic [HEIGHT_W-1:0] rd_data_q;
  logic [ADDR_W-1:0]   clr_addr_q;
  logic                clearing_q;

  // Sweep every entry once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem_q[clr_addr_q] <= HEIGHT_W'(RESET_HEIGHT);
    end else if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem_q[req_i.addr];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clearing_q;

endmodule

`default_nettype wire

FILE: sv/heightfield_triangle_height_query_unit.sv
// Top level of the heightfield triangle height query unit.
// Depends on htq_pkg, htq_item_if, htq_result_if and htq_store.
//
//   port       dir  handshake    payload
//   items_i    in   valid/ready  opcode, grid_row, grid_col, height_value, pos_x, pos_z
//   results_o  out  valid/ready  height_out, out_of_range
//
// A write item completes on acceptance; the next item may follow at once.
// A query (cell pick, three reads of the single-read-port store, multiply,
// divide) is loaded into the output register from divide, skipping the reads and
// multiply when out of range; the next item is taken once back in idle. One query is in flight at a time.
// After reset the store is cleared one entry a cycle, all 441 entries, without ready.
// A stalled result holds in the output register; the next item is still taken.
`default_nettype none

module heightfield_triangle_height_query_unit import htq_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  htq_item_if.sink     items_i,
  htq_result_if.source results_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CELL = 3'd1;
  localparam logic [2:0] ST_RDA  = 3'd2;
  localparam logic [2:0] ST_RDB  = 3'd3;
  localparam logic [2:0] ST_RDC  = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;

  logic [2:0] state_q, state_d;

  htq_mem_req_t        mem_req;
  logic [HEIGHT_W-1:0] rd_data;
  logic                clearing;

  logic accept;
  logic out_free;

  // Query registers
  logic [OFF_W-1:0]           uoff_q, voff_q;
  logic [CELLQ_W-1:0]         qi_q, qj_q;
  logic [INDEX_W-1:0]         ci_q, cj_q;
  logic [WGT_W-1:0]           a_q, b_q;
  logic                       upper_q;
  logic                       oor_q;
  logic signed [HEIGHT_W-1:0] h10_q, h01_q;
  logic signed [HEIGHT_W-1:0] base_q;
  logic signed [PROD_W-1:0]   p1_q, p2_q;

  // Output register
  logic                       out_valid_q;
  logic signed [HEIGHT_W-1:0] out_height_q;
  logic                       out_oor_q;

  // Combinational helpers
  logic [OFF_W-1:0]           uoff_in, voff_in;
  logic [OFF_W-1:0]           rem_u, rem_v;
  logic [WGT_W-1:0]           a_cell, b_cell;
  logic                       in_range;
  logic signed [HEIGHT_W-1:0] corner;
  logic signed [DIFF_W-1:0]   d1, d2;
  logic [WGT_W-1:0]           w1, w2;
  logic signed [NUM_W-1:0]    num;
  logic [DIVQ_W-1:0]          quot;
  logic signed [HEIGHT_W-1:0] blend;

  htq_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mem_req),
    .rd_data_o  (rd_data),
    .clearing_o (clearing)
  );

  assign items_i.ready = (state_q == ST_IDLE) && !clearing;
  assign accept        = items_i.valid && items_i.ready;
  assign out_free      = !out_valid_q || results_o.ready;

  // Shift positions so that cell indexes are non-negative
  assign uoff_in = OFF_W'(COORD_W'(items_i.pos_x) + OFF_W'(SHIFT_UNITS));
  assign voff_in = OFF_W'(SHIFT_UNITS) - OFF_W'(items_i.pos_z);

  // In-cell offsets and range test from the registered cell quotients
  assign rem_u    = uoff_q - OFF_W'(qi_q) * OFF_W'(CELL_UNITS);
  assign rem_v    = voff_q - OFF_W'(qj_q) * OFF_W'(CELL_UNITS);
  assign a_cell   = rem_u[WGT_W-1:0];
  assign b_cell   = rem_v[WGT_W-1:0];
  assign in_range = (qi_q >= CELLQ_W'(OFFSET_CELLS))
                 && (qi_q <= CELLQ_W'(OFFSET_CELLS + GRID_POINTS - 2))
                 && (qj_q >= CELLQ_W'(OFFSET_CELLS))
                 && (qj_q <= CELLQ_W'(OFFSET_CELLS + GRID_POINTS - 2));

  // Edge differences and weights of the chosen triangle
  assign corner = signed'(rd_data);
  always_comb begin
    if (upper_q) begin
      d1 = DIFF_W'(h01_q) - DIFF_W'(corner);
      d2 = DIFF_W'(h10_q) - DIFF_W'(corner);
      w1 = WGT_W'(CELL_UNITS) - a_q;
      w2 = WGT_W'(CELL_UNITS) - b_q;
    end else begin
      d1 = DIFF_W'(h10_q) - DIFF_W'(corner);
      d2 = DIFF_W'(h01_q) - DIFF_W'(corner);
      w1 = a_q;
      w2 = b_q;
    end
  end

  // Blend sum, biased non-negative, then floor divide by the cell size
  assign num   = NUM_W'(base_q) * NUM_W'(CELL_UNITS) + NUM_W'(p1_q) + NUM_W'(p2_q)
               + NUM_W'(NUM_BIAS);
  assign quot  = div_spacing(num[DIVX_W+7:8]);
  assign blend = signed'(HEIGHT_W'(quot - DIVQ_W'(32768)));

  // Store requests
  always_comb begin
    mem_req = '0;
    mem_req.wdata = items_i.height_value;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && items_i.opcode == OP_WRITE
            && items_i.grid_row < INDEX_W'(GRID_POINTS)
            && items_i.grid_col < INDEX_W'(GRID_POINTS)) begin
          mem_req.we   = 1'b1;
          mem_req.addr = ADDR_W'(items_i.grid_row) * ADDR_W'(GRID_POINTS)
                       + ADDR_W'(items_i.grid_col);
        end
      end
      ST_RDA: begin
        mem_req.re   = 1'b1;
        mem_req.addr = ADDR_W'(ci_q + 1'b1) * ADDR_W'(GRID_POINTS) + ADDR_W'(cj_q);
      end
      ST_RDB: begin
        mem_req.re   = 1'b1;
        mem_req.addr = ADDR_W'(ci_q) * ADDR_W'(GRID_POINTS) + ADDR_W'(cj_q + 1'b1);
      end
      ST_RDC: begin
        mem_req.re = 1'b1;
        if (upper_q) begin
          mem_req.addr = ADDR_W'(ci_q + 1'b1) * ADDR_W'(GRID_POINTS)
                       + ADDR_W'(cj_q + 1'b1);
        end else begin
          mem_req.addr = ADDR_W'(ci_q) * ADDR_W'(GRID_POINTS) + ADDR_W'(cj_q);
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && items_i.opcode == OP_QUERY) state_d = ST_CELL;
      ST_CELL: state_d = in_range ? ST_RDA : ST_DIV;
      ST_RDA:  state_d = ST_RDB;
      ST_RDB:  state_d = ST_RDC;
      ST_RDC:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      uoff_q <= uoff_in;
      voff_q <= voff_in;
      qi_q   <= CELLQ_W'(div_spacing(DIVX_W'(uoff_in[OFF_W-1:8])));
      qj_q   <= CELLQ_W'(div_spacing(DIVX_W'(voff_in[OFF_W-1:8])));
    end
    if (state_q == ST_CELL) begin
      ci_q    <= INDEX_W'(qi_q - CELLQ_W'(OFFSET_CELLS));
      cj_q    <= INDEX_W'(qj_q - CELLQ_W'(OFFSET_CELLS));
      a_q     <= a_cell;
      b_q     <= b_cell;
      upper_q <= ((WGT_W+1)'(a_cell) + (WGT_W+1)'(b_cell)) >= (WGT_W+1)'(CELL_UNITS);
      oor_q   <= !in_range;
    end
    if (state_q == ST_RDB) begin
      h10_q <= signed'(rd_data);
    end
    if (state_q == ST_RDC) begin
      h01_q <= signed'(rd_data);
    end
    if (state_q == ST_MUL) begin
      base_q <= corner;
      p1_q   <= PROD_W'(d1) * PROD_W'(signed'({1'b0, w1}));
      p2_q   <= PROD_W'(d2) * PROD_W'(signed'({1'b0, w2}));
    end
  end

  // Output register: load a finished query, drop on handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DIV && out_free) begin
      out_valid_q <= 1'b1;
    end else if (results_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV && out_free) begin
      out_height_q <= oor_q ? '0 : blend;
      out_oor_q    <= oor_q;
    end
  end

  assign results_o.valid        = out_valid_q;
  assign results_o.height_out   = out_height_q;
  assign results_o.out_of_range = out_oor_q;

`ifndef SYNTHESIS
  // No item is taken while the store is being cleared
  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !items_i.ready)
    else $error("item accepted during store clearing");

  // Store writes only come from an accepted write item in idle
  a_write_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (state_q == ST_IDLE && accept))
    else $error("store write outside idle");

  // An out-of-range result carries a zero height
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (results_o.valid && results_o.out_of_range) |-> (results_o.height_out == '0))
    else $error("out-of-range result with nonzero height");

  // A result is loaded only when the previous one has left
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (results_o.valid && !results_o.ready) |=> results_o.valid)
    else $error("pending result lost");
`endif

endmodule

`default_nettype wire

FILE: sim/htq_height_checker.sv
// Checker for the heightfield triangle height query unit: watches both channels,
// keeps its own copy of the height grid, predicts each query result and compares.
// Depends on htq_pkg, htq_item_if and htq_result_if.
`default_nettype none

module htq_height_checker import htq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  htq_item_if       items,
  htq_result_if     results,
  output int        fail_count,
  output int        awaited_count
);

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] height;
    logic                       out_of_range;
  } height_result_t;

  logic signed [HEIGHT_W-1:0] grid_heights [GRID_POINTS][GRID_POINTS];
  height_result_t             expected_heights [$];

  // Quotient rounded toward minus infinity
  function automatic longint floor_quot(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // Height of the triangle plane under (px, pz), or the out-of-range flag
  function automatic height_result_t predict_height(input logic signed [COORD_W-1:0] px,
                                                    input logic signed [COORD_W-1:0] pz);
    height_result_t r;
    longint u, v, ci, cj, a, b, num;
    longint h00, h10, h01, h11;
    r.height       = '0;
    r.out_of_range = 1'b0;
    u  = longint'(px) + BASE_UNITS;
    v  = BASE_UNITS - longint'(pz);
    ci = floor_quot(u, CELL_UNITS);
    cj = floor_quot(v, CELL_UNITS);
    if (ci < 0 || ci > GRID_POINTS - 2 || cj < 0 || cj > GRID_POINTS - 2) begin
      r.out_of_range = 1'b1;
      return r;
    end
    a   = u - ci * CELL_UNITS;
    b   = v - cj * CELL_UNITS;
    h10 = grid_heights[ci+1][cj];
    h01 = grid_heights[ci][cj+1];
    if (a + b < CELL_UNITS) begin
      h00 = grid_heights[ci][cj];
      num = h00 * CELL_UNITS + (h10 - h00) * a + (h01 - h00) * b;
    end else begin
      h11 = grid_heights[ci+1][cj+1];
      num = h11 * CELL_UNITS + (h01 - h11) * (CELL_UNITS - a) + (h10 - h11) * (CELL_UNITS - b);
    end
    r.height = HEIGHT_W'(floor_quot(num, CELL_UNITS));
    return r;
  endfunction

  // Count a failure; report only the first few
  task automatic note_failure(input string what, input height_result_t want,
                              input height_result_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("height query %s at %0t: expected height %0d oor %0b, got height %0d oor %0b",
               what, $realtime, want.height, want.out_of_range, got.height, got.out_of_range);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track_items
    height_result_t got, want;
    int i, j;
    if (!rst_ni) begin
      for (i = 0; i < GRID_POINTS; i++)
        for (j = 0; j < GRID_POINTS; j++)
          grid_heights[i][j] = RESET_HEIGHT;
      expected_heights.delete();
      fail_count = 0;
    end else begin
      // Apply a write or queue the expected result of a query
      if (items.valid && items.ready) begin
        if (items.opcode == OP_WRITE) begin
          if (items.grid_row < GRID_POINTS && items.grid_col < GRID_POINTS)
            grid_heights[items.grid_row][items.grid_col] = items.height_value;
        end else begin
          expected_heights.push_back(predict_height(items.pos_x, items.pos_z));
        end
      end
      // Compare each result with the oldest one awaited
      if (results.valid && results.ready) begin
        got.height       = results.height_out;
        got.out_of_range = results.out_of_range;
        if (expected_heights.size() == 0) begin
          note_failure("unexpected result", '0, got);
        end else begin
          want = expected_heights.pop_front();
          if (got.height !== want.height || got.out_of_range !== want.out_of_range)
            note_failure("mismatch", want, got);
        end
      end
    end
    awaited_count = expected_heights.size();
  end

endmodule

`default_nettype wire

FILE: sim/heightfield_triangle_height_query_unit_tb.sv
// Testbench top for the heightfield triangle height query unit: drives write and
// query items with bursty timing, stalls the result side, and gives the verdict.
// Depends on htq_pkg, the two channel interfaces, the unit and htq_height_checker.
`default_nettype none

module heightfield_triangle_height_query_unit_tb;
  import htq_pkg::*;

  typedef struct packed {
    htq_op_e                    op;
    logic [INDEX_W-1:0]         row;
    logic [INDEX_W-1:0]         col;
    logic signed [HEIGHT_W-1:0] hval;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  pz;
  } grid_item_t;

  typedef enum int {
    STALL_NONE,
    STALL_HALF,
    STALL_MOST,
    STALL_TOGGLE
  } stall_mode_e;

  localparam int RANDOM_ITEMS = 1150;
  localparam int HOLDOFF_AT   = 500;
  localparam int HOLDOFF_LEN  = 300;
  localparam int DRAIN_CYCLES = 20;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   awaited_count;
  int   items_sent   = 0;
  int   burst_left   = 0;
  bit   holdoff_done = 1'b0;

  htq_item_if   items_if ();
  htq_result_if results_if ();

  heightfield_triangle_height_query_unit uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .items_i   (items_if),
    .results_o (results_if)
  );

  htq_height_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .items         (items_if),
    .results       (results_if),
    .fail_count    (fail_count),
    .awaited_count (awaited_count)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic grid_item_t write_item(input int row, input int col, input int hval);
    grid_item_t it;
    it.op   = OP_WRITE;
    it.row  = INDEX_W'(row);
    it.col  = INDEX_W'(col);
    it.hval = HEIGHT_W'(hval);
    it.px   = COORD_W'($urandom);
    it.pz   = COORD_W'($urandom);
    return it;
  endfunction

  function automatic grid_item_t query_item(input int px, input int pz);
    grid_item_t it;
    it.op   = OP_QUERY;
    it.row  = INDEX_W'($urandom);
    it.col  = INDEX_W'($urandom);
    it.hval = HEIGHT_W'($urandom);
    it.px   = COORD_W'(px);
    it.pz   = COORD_W'(pz);
    return it;
  endfunction

  // Mostly in-grid writes and queries; some edge, out-of-grid and raw values
  function automatic grid_item_t random_grid_item();
    grid_item_t it;
    int pick;
    it   = query_item($urandom, $urandom);
    pick = $urandom_range(0, 9);
    if ($urandom_range(0, 9) < 4) begin
      it.op = OP_WRITE;
      if (pick < 9) begin
        it.row = INDEX_W'($urandom_range(0, GRID_POINTS - 1));
        it.col = INDEX_W'($urandom_range(0, GRID_POINTS - 1));
      end
      if ($urandom_range(0, 1) == 0)
        it.hval = HEIGHT_W'(RESET_HEIGHT + int'($urandom_range(0, 2048)) - 1024);
    end else if (pick < 7) begin
      it.px = COORD_W'(int'($urandom_range(0, 2 * BASE_UNITS - 1)) - BASE_UNITS);
      it.pz = COORD_W'(BASE_UNITS - int'($urandom_range(0, 2 * BASE_UNITS - 1)));
    end else if (pick < 9) begin
      it.px = COORD_W'(($urandom_range(0, 1) ? BASE_UNITS : -BASE_UNITS)
                       + int'($urandom_range(0, 6)) - 3);
      it.pz = COORD_W'(($urandom_range(0, 1) ? BASE_UNITS : -BASE_UNITS)
                       + int'($urandom_range(0, 6)) - 3);
    end
    return it;
  endfunction

  // Offer one item in the current burst, opening a new burst after a gap
  task automatic send_grid_item(input grid_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        items_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    items_if.valid        <= 1'b1;
    items_if.opcode       <= it.op;
    items_if.grid_row     <= it.row;
    items_if.grid_col     <= it.col;
    items_if.height_value <= it.hval;
    items_if.pos_x        <= it.px;
    items_if.pos_z        <= it.pz;
    @(posedge clk_i);
    while (!items_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  initial begin : item_sender
    grid_item_t it;
    int counted;
    rst_ni                <= 1'b0;
    items_if.valid        <= 1'b0;
    items_if.opcode       <= OP_WRITE;
    items_if.grid_row     <= '0;
    items_if.grid_col     <= '0;
    items_if.height_value <= '0;
    items_if.pos_x        <= '0;
    items_if.pos_z        <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: corner writes, ignored writes, both triangles, grid edges
    send_grid_item(query_item(0, 0));
    send_grid_item(write_item(0, 0, 32767));
    send_grid_item(write_item(20, 20, -32768));
    send_grid_item(write_item(0, 20, -1));
    send_grid_item(write_item(20, 0, 1));
    send_grid_item(write_item(21, 0, 123));
    send_grid_item(write_item(0, 31, 456));
    send_grid_item(write_item(31, 31, -5));
    send_grid_item(write_item(11, 10, -32768));
    send_grid_item(write_item(10, 11, -32768));
    send_grid_item(write_item(10, 10, 32767));
    send_grid_item(write_item(11, 11, 32767));
    send_grid_item(query_item(0, 0));
    send_grid_item(query_item(640, -639));
    send_grid_item(query_item(640, -640));
    send_grid_item(query_item(1279, -1279));
    send_grid_item(query_item(-BASE_UNITS, BASE_UNITS));
    send_grid_item(query_item(-BASE_UNITS - 1, 0));
    send_grid_item(query_item(0, BASE_UNITS + 1));
    send_grid_item(query_item(BASE_UNITS - 1, 1 - BASE_UNITS));
    send_grid_item(query_item(BASE_UNITS, 0));
    send_grid_item(query_item(0, -BASE_UNITS));
    send_grid_item(query_item(-32768, -32768));
    send_grid_item(query_item(32767, 32767));
    send_grid_item(query_item(333, -777));

    // Random: ignored writes do not count
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      it = random_grid_item();
      send_grid_item(it);
      if (it.op == OP_QUERY || (it.row < GRID_POINTS && it.col < GRID_POINTS))
        counted++;
    end
    items_if.valid <= 1'b0;

    // Let the checker see the last item, drain, then allow for stray results
    @(posedge clk_i);
    while (awaited_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Stall the result side in stretches of varying pattern, with one long hold-off
  initial begin : result_receiver
    stall_mode_e mode;
    int stretch;
    results_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!holdoff_done && items_sent >= HOLDOFF_AT) begin
        results_if.ready <= 1'b0;
        repeat (HOLDOFF_LEN) @(posedge clk_i);
        holdoff_done = 1'b1;
      end
      mode    = stall_mode_e'($urandom_range(0, 3));
      stretch = $urandom_range(4, 60);
      repeat (stretch) begin
        case (mode)
          STALL_NONE: results_if.ready <= 1'b1;
          STALL_HALF: results_if.ready <= 1'($urandom_range(0, 1));
          STALL_MOST: results_if.ready <= ($urandom_range(0, 3) == 0);
          default:    results_if.ready <= ~results_if.ready;
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
